### design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the path travel-time cost block
// Widths, fixed-point constants, the arctangent table, and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;

	localparam int COORD_W = 24;
	localparam int DELTA_W = COORD_W + 1;
	localparam int CX_W    = 36;           // CORDIC x/y with 8 guard bits and growth
	localparam int XP_W    = CX_W - 1;     // magnitude without sign
	localparam int XLO_W   = 17;           // low slice of magnitude for the multiplier
	localparam int ZW      = 32;           // angle in 2^-32 turn
	localparam int ACC_W   = 40;
	localparam int HALF_W  = ACC_W / 2;
	localparam int OUT_W   = 32;
	localparam int CFG_W   = 16;
	localparam int MUL_W   = 24;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SUM_W   = 64;
	localparam int LIN_W   = 48;
	localparam int RAD_W   = 48;
	localparam int CNT_W   = $clog2(CORDIC_STEPS);
	localparam int ATAN_DEPTH = 24;
	localparam int ATAN_IW    = $clog2(ATAN_DEPTH);

	localparam int APB_W    = 32;
	localparam int PADDR_W  = 3;

	localparam logic [MUL_W-1:0] INV_GAIN_Q24 = 24'd10188014;
	localparam logic [MUL_W-1:0] TWO_PI_Q20   = 24'd6588397;
	localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
	localparam logic [RAD_W-1:0] RAD_CLAMP    = RAD_W'(1) << (RAD_W - 1);
	localparam logic [SUM_W-1:0] OUT_MAX      = SUM_W'({OUT_W{1'b1}});

	localparam logic [CFG_W-1:0] INV_LIN_RST = 16'd6302;
	localparam logic [CFG_W-1:0] INV_ANG_RST = 16'd4096;

	// register index, taken from paddr[2]
	localparam logic REG_INV_LIN = 1'b0;
	localparam logic REG_INV_ANG = 1'b1;

	typedef enum logic [2:0] {
		MS_LEN_LO = 3'd0,
		MS_LEN_HI = 3'd1,
		MS_LIN_LO = 3'd2,
		MS_LIN_HI = 3'd3,
		MS_RAD_LO = 3'd4,
		MS_RAD_HI = 3'd5,
		MS_ANG_LO = 3'd6,
		MS_ANG_HI = 3'd7
	} msel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	// rounding constant and slice shift of each product pair
	typedef enum logic [1:0] {
		AS_LEN = 2'd0,
		AS_LIN = 2'd1,
		AS_RAD = 2'd2,
		AS_ANG = 2'd3
	} acc_sel_t;

	typedef struct packed {
		logic     load;
		logic     first_upd;
		logic     cinit;
		logic     citer;
		logic     mul_en;
		msel_t    msel;
		acc_op_t  acc_op;
		acc_sel_t acc_sel;
		logic     step_upd;
		logic     fturn;
		logic     save_lin;
		logic     save_rad;
		logic     emit;
	} ptt_cmd_t;

	typedef struct packed {
		logic iter_last;
		logic first;
		logic last;
		logic out_full;
	} ptt_stat_t;

	function automatic logic [ZW-1:0] atan_turn(input logic [ATAN_IW-1:0] idx);
		unique case (idx)
			5'd0:    return 32'h20000000;
			5'd1:    return 32'h12E4051E;
			5'd2:    return 32'h09FB385B;
			5'd3:    return 32'h051111D4;
			5'd4:    return 32'h028B0D43;
			5'd5:    return 32'h0145D7E1;
			5'd6:    return 32'h00A2F61E;
			5'd7:    return 32'h00517C55;
			5'd8:    return 32'h0028BE53;
			5'd9:    return 32'h00145F2F;
			5'd10:   return 32'h000A2F98;
			5'd11:   return 32'h000517CC;
			5'd12:   return 32'h00028BE6;
			5'd13:   return 32'h000145F3;
			5'd14:   return 32'h0000A2FA;
			5'd15:   return 32'h0000517D;
			5'd16:   return 32'h000028BE;
			5'd17:   return 32'h0000145F;
			5'd18:   return 32'h00000A30;
			5'd19:   return 32'h00000518;
			5'd20:   return 32'h0000028C;
			5'd21:   return 32'h00000146;
			5'd22:   return 32'h000000A3;
			5'd23:   return 32'h00000051;
			default: return '0;
		endcase
	endfunction

	// short way round: a change of half a turn stays half a turn
	function automatic logic [ANGLE_BITS-1:0] ang_abs(input logic [ANGLE_BITS-1:0] d);
		return d[ANGLE_BITS-1] ? (ANGLE_BITS'(~d) + ANGLE_BITS'(1)) : d;
	endfunction

endpackage

### design/ptt_pose_if.sv
// ----------------------------------------------------------------------------
// ptt_pose_if: pose channel
// One word per pose: coordinates and path start and end marks.
// ----------------------------------------------------------------------------
interface ptt_pose_if;
	import ptt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pose_x;
	logic signed [COORD_W-1:0] pose_y;
	logic                      first_pose;
	logic                      last_pose;

	modport source (output valid, pose_x, pose_y, first_pose, last_pose, input ready);
	modport sink   (input valid, pose_x, pose_y, first_pose, last_pose, output ready);

endinterface

### design/ptt_cost_if.sv
// ----------------------------------------------------------------------------
// ptt_cost_if: cost channel
// One word per finished path: cost, length, turn and saturation flag.
// ----------------------------------------------------------------------------
interface ptt_cost_if;
	import ptt_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] travel_cost;
	logic [OUT_W-1:0] path_length;
	logic [OUT_W-1:0] turn_total;
	logic             cost_saturated;

	modport source (output valid, travel_cost, path_length, turn_total, cost_saturated,
		input ready);
	modport sink   (input valid, travel_cost, path_length, turn_total, cost_saturated,
		output ready);

endinterface

### design/ptt_dp.sv
// ----------------------------------------------------------------------------
// ptt_dp: path cost datapath
// Vectoring CORDIC stage, shared 24x24 multiplier with slice accumulator,
// saturating path sums and the output register.
// ----------------------------------------------------------------------------
module ptt_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptt_pkg::ptt_cmd_t                  cmd,
	output ptt_pkg::ptt_stat_t                 stat,
	input  logic signed [ptt_pkg::COORD_W-1:0] pose_x,
	input  logic signed [ptt_pkg::COORD_W-1:0] pose_y,
	input  logic                               first_pose,
	input  logic                               last_pose,
	input  logic [ptt_pkg::CFG_W-1:0]          inv_lin,
	input  logic [ptt_pkg::CFG_W-1:0]          inv_ang,
	ptt_cost_if.source                         res
);
	import ptt_pkg::*;

	// latched pose
	logic signed [COORD_W-1:0] pose_x_q, pose_y_q;
	logic                      first_q, last_q;

	// path state
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic [ANGLE_BITS-1:0]     last_head_q;
	logic [ACC_W-1:0]          dist_q, turn_q;
	logic                      ovf_q;

	// CORDIC
	logic signed [CX_W-1:0] cx_q, cy_q;
	logic [ZW-1:0]          cz_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   zero_q;

	// multiplier and accumulator
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  acc_q;
	logic [LIN_W-1:0]  lin_q;
	logic [RAD_W-1:0]  rad_q;

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] cost_q, plen_q, tturn_q;
	logic             sat_q;

	logic signed [DELTA_W-1:0] dx, dy;
	logic signed [CX_W-1:0]    dxs, dys, sx, sy;
	logic [ZW-1:0]             at;
	logic [XP_W-1:0]           xpos;
	logic [MUL_W-1:0]          mul_a, mul_b;
	logic [SUM_W-1:0]          rnd, prod_sh;
	logic [OUT_W-1:0]          len;
	logic [ZW-1:0]             zr;
	logic [ANGLE_BITS-1:0]     head, turn_inc;
	logic [ACC_W:0]            dist_nx, turn_nx;
	logic [SUM_W-1:0]          rad_big, cost_full;

	assign dx  = DELTA_W'(pose_x_q) - DELTA_W'(last_x_q);
	assign dy  = DELTA_W'(pose_y_q) - DELTA_W'(last_y_q);
	assign dxs = CX_W'(dx) <<< 8;
	assign dys = CX_W'(dy) <<< 8;
	assign sx  = cx_q >>> cnt_q;
	assign sy  = cy_q >>> cnt_q;
	assign at  = atan_turn(ATAN_IW'(cnt_q));

	assign xpos = cx_q[CX_W-1] ? '0 : cx_q[XP_W-1:0];

	always_comb begin
		unique case (cmd.msel)
			MS_LEN_LO: begin mul_a = MUL_W'(xpos[XLO_W-1:0]);      mul_b = INV_GAIN_Q24; end
			MS_LEN_HI: begin mul_a = MUL_W'(xpos[XP_W-1:XLO_W]);   mul_b = INV_GAIN_Q24; end
			MS_LIN_LO: begin mul_a = MUL_W'(dist_q[HALF_W-1:0]);   mul_b = MUL_W'(inv_lin); end
			MS_LIN_HI: begin mul_a = MUL_W'(dist_q[ACC_W-1:HALF_W]); mul_b = MUL_W'(inv_lin); end
			MS_RAD_LO: begin mul_a = MUL_W'(turn_q[HALF_W-1:0]);   mul_b = TWO_PI_Q20; end
			MS_RAD_HI: begin mul_a = MUL_W'(turn_q[ACC_W-1:HALF_W]); mul_b = TWO_PI_Q20; end
			MS_ANG_LO: begin mul_a = rad_q[MUL_W-1:0];             mul_b = MUL_W'(inv_ang); end
			MS_ANG_HI: begin mul_a = rad_q[RAD_W-1:MUL_W];         mul_b = MUL_W'(inv_ang); end
			default:   begin mul_a = '0;                           mul_b = '0; end
		endcase
	end

	always_comb begin
		unique case (cmd.acc_sel)
			AS_LEN: begin
				rnd     = SUM_W'(1) << 31;
				prod_sh = SUM_W'(prod_q) << XLO_W;
			end
			AS_LIN: begin
				rnd     = SUM_W'(128);
				prod_sh = SUM_W'(prod_q) << HALF_W;
			end
			AS_RAD: begin
				rnd     = SUM_W'(1) << (ANGLE_BITS + 3);
				prod_sh = SUM_W'(prod_q) << HALF_W;
			end
			AS_ANG: begin
				rnd     = SUM_W'(2048);
				prod_sh = SUM_W'(prod_q) << MUL_W;
			end
			default: begin
				rnd     = '0;
				prod_sh = '0;
			end
		endcase
	end

	// step length and heading rounded half up; a zero step has neither
	assign len  = zero_q ? '0 : acc_q[SUM_W-1:SUM_W-OUT_W];
	assign zr   = cz_q + (ZW'(1) << (31 - ANGLE_BITS));
	assign head = zero_q ? '0 : zr[ZW-1 -: ANGLE_BITS];

	assign turn_inc = cmd.fturn ? ang_abs(last_head_q) : ang_abs(head - last_head_q);
	assign dist_nx  = {1'b0, dist_q} + (ACC_W+1)'(len);
	assign turn_nx  = {1'b0, turn_q} + (ACC_W+1)'(turn_inc);

	assign rad_big   = acc_q >> (ANGLE_BITS + 4);
	assign cost_full = SUM_W'(lin_q) + (acc_q >> 12);

	assign stat.iter_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign stat.first     = first_q;
	assign stat.last      = last_q;
	assign stat.out_full  = out_valid_q && !res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_head_q <= '0;
			dist_q      <= '0;
			turn_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				first_q <= first_pose;
				last_q  <= last_pose;
			end
			if (cmd.first_upd) begin
				last_x_q    <= pose_x_q;
				last_y_q    <= pose_y_q;
				last_head_q <= '0;
				dist_q      <= '0;
				turn_q      <= '0;
				ovf_q       <= 1'b0;
			end else if (cmd.step_upd) begin
				last_x_q    <= pose_x_q;
				last_y_q    <= pose_y_q;
				last_head_q <= head;
				dist_q      <= dist_nx[ACC_W] ? ACC_MAX : dist_nx[ACC_W-1:0];
				turn_q      <= turn_nx[ACC_W] ? ACC_MAX : turn_nx[ACC_W-1:0];
				if (dist_nx[ACC_W] || turn_nx[ACC_W]) begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.fturn) begin
				turn_q <= turn_nx[ACC_W] ? ACC_MAX : turn_nx[ACC_W-1:0];
				if (turn_nx[ACC_W]) begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.emit) begin
				last_head_q <= '0;
				dist_q      <= '0;
				turn_q      <= '0;
				ovf_q       <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pose_x_q <= pose_x;
			pose_y_q <= pose_y;
		end
		if (cmd.cinit) begin
			zero_q <= (dx == '0) && (dy == '0);
			cnt_q  <= '0;
			if (dx < 0) begin
				cx_q <= -dxs;
				cy_q <= -dys;
				cz_q <= ZW'(1) << (ZW - 1);
			end else begin
				cx_q <= dxs;
				cy_q <= dys;
				cz_q <= '0;
			end
		end else if (cmd.citer) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!cy_q[CX_W-1]) begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - at;
			end
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cmd.acc_op)
			ACC_LOAD: acc_q <= SUM_W'(prod_q) + rnd;
			ACC_ADD:  acc_q <= acc_q + prod_sh;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.save_lin) begin
			lin_q <= acc_q[8 +: LIN_W];
		end
		if (cmd.save_rad) begin
			rad_q <= (rad_big > SUM_W'(RAD_CLAMP)) ? RAD_CLAMP : rad_big[RAD_W-1:0];
		end
		if (cmd.emit) begin
			cost_q  <= (cost_full > OUT_MAX) ? '1 : cost_full[OUT_W-1:0];
			plen_q  <= (SUM_W'(dist_q) > OUT_MAX) ? '1 : dist_q[OUT_W-1:0];
			tturn_q <= (SUM_W'(turn_q) > OUT_MAX) ? '1 : turn_q[OUT_W-1:0];
			sat_q   <= ovf_q || (cost_full > OUT_MAX) || (SUM_W'(dist_q) > OUT_MAX)
				|| (SUM_W'(turn_q) > OUT_MAX);
		end
	end

	assign res.valid          = out_valid_q;
	assign res.travel_cost    = cost_q;
	assign res.path_length    = plen_q;
	assign res.turn_total     = tturn_q;
	assign res.cost_saturated = sat_q;

endmodule

### design/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl: path cost sequencer
// Steps the datapath through the CORDIC pass, length scaling, sum update and,
// on the final pose, the cost evaluation; a start pose skips the CORDIC pass and length scaling.
// ----------------------------------------------------------------------------
module ptt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptt_pkg::ptt_stat_t stat,
	output ptt_pkg::ptt_cmd_t  cmd
);
	import ptt_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_INIT  = 19'h00002,
		ST_ITER  = 19'h00004,
		ST_LEN0  = 19'h00008,
		ST_LEN1  = 19'h00010,
		ST_LEN2  = 19'h00020,
		ST_STEP  = 19'h00040,
		ST_FTURN = 19'h00080,
		ST_L0    = 19'h00100,
		ST_L1    = 19'h00200,
		ST_L2    = 19'h00400,
		ST_R0    = 19'h00800,
		ST_R1    = 19'h01000,
		ST_R2    = 19'h02000,
		ST_A0    = 19'h04000,
		ST_A1    = 19'h08000,
		ST_A2    = 19'h10000,
		ST_A3    = 19'h20000,
		ST_OUT   = 19'h40000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_INIT;
				end
			end
			ST_INIT: begin
				if (stat.first) begin
					cmd.first_upd = 1'b1;
					state_d = stat.last ? ST_FTURN : ST_IDLE;
				end else begin
					cmd.cinit = 1'b1;
					state_d   = ST_ITER;
				end
			end
			ST_ITER: begin
				cmd.citer = 1'b1;
				if (stat.iter_last) begin
					state_d = ST_LEN0;
				end
			end
			ST_LEN0: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MS_LEN_LO;
				state_d    = ST_LEN1;
			end
			ST_LEN1: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_LEN_HI;
				cmd.acc_op  = ACC_LOAD;
				cmd.acc_sel = AS_LEN;
				state_d     = ST_LEN2;
			end
			ST_LEN2: begin
				cmd.acc_op  = ACC_ADD;
				cmd.acc_sel = AS_LEN;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				cmd.step_upd = 1'b1;
				state_d = stat.last ? ST_FTURN : ST_IDLE;
			end
			ST_FTURN: begin
				cmd.fturn = 1'b1;
				state_d   = ST_L0;
			end
			ST_L0: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MS_LIN_LO;
				state_d    = ST_L1;
			end
			ST_L1: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_LIN_HI;
				cmd.acc_op  = ACC_LOAD;
				cmd.acc_sel = AS_LIN;
				state_d     = ST_L2;
			end
			ST_L2: begin
				cmd.acc_op  = ACC_ADD;
				cmd.acc_sel = AS_LIN;
				state_d     = ST_R0;
			end
			ST_R0: begin
				cmd.save_lin = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.msel     = MS_RAD_LO;
				state_d      = ST_R1;
			end
			ST_R1: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_RAD_HI;
				cmd.acc_op  = ACC_LOAD;
				cmd.acc_sel = AS_RAD;
				state_d     = ST_R2;
			end
			ST_R2: begin
				cmd.acc_op  = ACC_ADD;
				cmd.acc_sel = AS_RAD;
				state_d     = ST_A0;
			end
			ST_A0: begin
				cmd.save_rad = 1'b1;
				state_d      = ST_A1;
			end
			ST_A1: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MS_ANG_LO;
				state_d    = ST_A2;
			end
			ST_A2: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_ANG_HI;
				cmd.acc_op  = ACC_LOAD;
				cmd.acc_sel = AS_ANG;
				state_d     = ST_A3;
			end
			ST_A3: begin
				cmd.acc_op  = ACC_ADD;
				cmd.acc_sel = AS_ANG;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// hold until the previous result word has gone
				if (!stat.out_full) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/path_travel_time_cost.sv
// ----------------------------------------------------------------------------
// path_travel_time_cost: travel-time cost of a planned path
// Sums step length and heading change over the poses of a path and emits one
// cost word on the final pose. APB register port for the speed reciprocals.
// ----------------------------------------------------------------------------
// Poses arrive one word at a time; a pose with first_pose set starts a path by
// resetting the path sums, with no CORDIC pass. Any other pose runs one vectoring
// CORDIC pass, one iteration a cycle through a single shift-add stage, then
// scales the magnitude on the shared 24x24 multiplier and updates the sums before
// the next pose is taken. A pose with last_pose set then computes the cost, which
// takes six products on the same multiplier, and waits further only while an
// earlier cost word is still held in the output register. Register 0 (address 0)
// is inv_linear_speed and register 1 (address 4) is inv_angular_speed, both Q4.12;
// write them only while no path is in progress.
module path_travel_time_cost (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ptt_pkg::PADDR_W-1:0] paddr,
	input  logic [ptt_pkg::APB_W-1:0]   pwdata,
	output logic [ptt_pkg::APB_W-1:0]   prdata,
	output logic                        pready,
	ptt_pose_if.sink                    pose,
	ptt_cost_if.source                  cost
);
	import ptt_pkg::*;

	logic [CFG_W-1:0] inv_lin_q, inv_ang_q;
	logic             cfg_wr;
	ptt_cmd_t         cmd;
	ptt_stat_t        stat;
	logic             in_ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_INV_ANG) ? APB_W'(inv_ang_q) : APB_W'(inv_lin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_lin_q <= INV_LIN_RST;
			inv_ang_q <= INV_ANG_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INV_LIN) begin
				inv_lin_q <= pwdata[CFG_W-1:0];
			end else begin
				inv_ang_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign pose.ready = in_ready;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pose.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.pose_x     (pose.pose_x),
		.pose_y     (pose.pose_y),
		.first_pose (pose.first_pose),
		.last_pose  (pose.last_pose),
		.inv_lin    (inv_lin_q),
		.inv_ang    (inv_ang_q),
		.res        (cost)
	);

	// a taken pose always keeps the block busy in the following cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.ready |=> !pose.ready)
		else $error("pose taken while previous pose still in work");

	// a start pose that does not end the path needs no CORDIC pass
	a_first_quick: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.ready && pose.first_pose && !pose.last_pose |=> ##1 pose.ready)
		else $error("start pose did not release the input");

	// a fresh cost word comes out of the busy sequence, never from idle
	a_cost_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cost.valid) |-> $past(!pose.ready))
		else $error("cost word raised while idle");

endmodule
